// ----- sv/kfmm_pkg.sv -----
`default_nettype none
package kfmm_pkg;

	localparam int DEF_ENTRIES     = 64;
	localparam int DEF_KEY_WIDTH   = 32;
	localparam int DEF_COUNT_WIDTH = 32;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ABSENT  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_SATURATE = 2'd3;

	localparam logic ACT_INC = 1'b0;
	localparam logic ACT_DEC = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] key;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] new_count;
		logic        table_empty;
		logic [31:0] max_key;
		logic [31:0] max_count;
		logic [31:0] min_key;
		logic [31:0] min_count;
	} out_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;      // capture input, reset search
		logic search;    // scan one slot for key and free slot
		logic update;    // apply the change to the found or free slot
		logic scan_init; // clear max/min trackers
		logic scan;      // scan one slot for max/min
		logic emit;      // drive the result strobe
	} dp_cmd_t;

	typedef struct packed {
		logic last; // slot pointer at the last entry
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- sv/key_frequency_min_max_tracker.sv -----
`default_nettype none
// Counts key occurrences in an ENTRIES-slot table and reports max/min keys. The done
// strobe follows a one-slot-per-cycle key search and a one-slot-per-cycle max/min scan,
// each reading a slot memory with a registered read, and the next transaction can be
// accepted in the done cycle. The result is on result from the cycle done is high
// and must be taken then.
module key_frequency_min_max_tracker #(
	parameter int ENTRIES     = kfmm_pkg::DEF_ENTRIES,
	parameter int KEY_WIDTH   = kfmm_pkg::DEF_KEY_WIDTH,
	parameter int COUNT_WIDTH = kfmm_pkg::DEF_COUNT_WIDTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  kfmm_pkg::in_item_t  in_item,
	output logic                done,
	output kfmm_pkg::out_item_t result
);
	import kfmm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	kfmm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	kfmm_dp #(
		.ENTRIES(ENTRIES), .KEY_WIDTH(KEY_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd), .sts(sts),
		.done(done), .result(result)
	);

endmodule
`default_nettype wire

// ----- sv/kfmm_ctrl.sv -----
`default_nettype none
module kfmm_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  kfmm_pkg::dp_sts_t  sts,
	output kfmm_pkg::dp_cmd_t  cmd
);
	import kfmm_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE       = 7'b0000001,
		S_SEARCH     = 7'b0000010,
		S_SEARCH_END = 7'b0000100,
		S_UPDATE     = 7'b0001000,
		S_SCAN       = 7'b0010000,
		S_SCAN_END   = 7'b0100000,
		S_EMIT       = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// The end states let the datapath compare the last slot read before moving on.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (sts.last) state_d = S_SEARCH_END;
			end
			S_SEARCH_END: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update    = 1'b1;
				cmd.scan_init = 1'b1;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last) state_d = S_SCAN_END;
			end
			S_SCAN_END: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

// ----- sv/kfmm_dp.sv -----
`default_nettype none
module kfmm_dp #(
	parameter int ENTRIES     = kfmm_pkg::DEF_ENTRIES,
	parameter int KEY_WIDTH   = kfmm_pkg::DEF_KEY_WIDTH,
	parameter int COUNT_WIDTH = kfmm_pkg::DEF_COUNT_WIDTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  kfmm_pkg::in_item_t  in_item,
	input  kfmm_pkg::dp_cmd_t   cmd,
	output kfmm_pkg::dp_sts_t   sts,
	output logic                done,
	output kfmm_pkg::out_item_t result
);
	import kfmm_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int MW = KEY_WIDTH + COUNT_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CONE = COUNT_WIDTH'(1);

	// Key and count share one slot memory with a registered read. Only the used
	// bits are reset; a slot is written whenever it becomes used.
	logic [MW-1:0]          mem_q [ENTRIES];
	logic [MW-1:0]          rd_s1;
	logic [ENTRIES-1:0]     used_q;

	logic [IW-1:0]          ptr_q, ptr_s1;
	logic                   search_s1, scan_s1;
	logic                   act_q;
	logic [KEY_WIDTH-1:0]   k_q;
	logic                   hit_q, free_ok_q;
	logic [IW-1:0]          hit_idx_q, free_idx_q;
	logic [COUNT_WIDTH-1:0] hit_cnt_q;
	logic [1:0]             status_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   any_q;
	logic [KEY_WIDTH-1:0]   max_k_q, min_k_q;
	logic [COUNT_WIDTH-1:0] max_c_q, min_c_q;

	logic [KEY_WIDTH-1:0]   rd_key;
	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic                   rd_used;
	logic                   mem_we;
	logic [IW-1:0]          mem_waddr;
	logic [MW-1:0]          mem_wdata;

	assign rd_key   = rd_s1[MW-1:COUNT_WIDTH];
	assign rd_cnt   = rd_s1[COUNT_WIDTH-1:0];
	assign rd_used  = used_q[ptr_s1];
	assign sts.last = (ptr_q == IW'(ENTRIES - 1));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = {k_q, hit_cnt_q + CONE};
		if (cmd.update) begin
			if (act_q == ACT_INC) begin
				if (hit_q) begin
					mem_we = (hit_cnt_q != CMAX);
				end else if (free_ok_q) begin
					mem_we    = 1'b1;
					mem_waddr = free_idx_q;
					mem_wdata = {k_q, CONE};
				end
			end else if (hit_q && hit_cnt_q > CONE) begin
				mem_we    = 1'b1;
				mem_wdata = {k_q, hit_cnt_q - CONE};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		rd_s1  <= mem_q[ptr_q];
		ptr_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			ptr_q     <= '0;
			search_s1 <= 1'b0;
			scan_s1   <= 1'b0;
			done      <= 1'b0;
		end else begin
			done      <= cmd.emit;
			search_s1 <= cmd.search;
			scan_s1   <= cmd.scan;
			if (cmd.load || cmd.update || (sts.last && (cmd.search || cmd.scan)))
				ptr_q <= '0;
			else if (cmd.search || cmd.scan)
				ptr_q <= ptr_q + IW'(1);
			if (cmd.update) begin
				if (act_q == ACT_INC) begin
					if (!hit_q && free_ok_q) used_q[free_idx_q] <= 1'b1;
				end else if (hit_q && hit_cnt_q <= CONE) begin
					used_q[hit_idx_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q     <= in_item.action;
			k_q       <= KEY_WIDTH'(in_item.key);
			hit_q     <= 1'b0;
			free_ok_q <= 1'b0;
		end
		if (search_s1) begin
			if (rd_used && rd_key == k_q && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= ptr_s1;
				hit_cnt_q <= rd_cnt;
			end
			if (!rd_used && !free_ok_q) begin
				free_ok_q  <= 1'b1;
				free_idx_q <= ptr_s1;
			end
		end
		if (cmd.update) begin
			status_q <= ST_OK;
			cnt_q    <= '0;
			if (act_q == ACT_INC) begin
				if (hit_q) begin
					if (hit_cnt_q == CMAX) begin
						status_q <= ST_SATURATE;
						cnt_q    <= CMAX;
					end else cnt_q <= hit_cnt_q + CONE;
				end else if (free_ok_q) begin
					cnt_q <= CONE;
				end else status_q <= ST_FULL;
			end else if (!hit_q) status_q <= ST_ABSENT;
			else if (hit_cnt_q > CONE) cnt_q <= hit_cnt_q - CONE;
		end
		if (cmd.scan_init) any_q <= 1'b0;
		if (scan_s1 && rd_used) begin
			any_q <= 1'b1;
			if (!any_q || rd_cnt > max_c_q) begin
				max_c_q <= rd_cnt;
				max_k_q <= rd_key;
			end
			if (!any_q || rd_cnt < min_c_q) begin
				min_c_q <= rd_cnt;
				min_k_q <= rd_key;
			end
		end
		if (cmd.emit) begin
			result.status      <= status_q;
			result.new_count   <= 32'(64'(cnt_q));
			result.table_empty <= !any_q;
			result.max_key     <= any_q ? 32'(64'(max_k_q)) : '0;
			result.max_count   <= any_q ? 32'(64'(max_c_q)) : '0;
			result.min_key     <= any_q ? 32'(64'(min_k_q)) : '0;
			result.min_count   <= any_q ? 32'(64'(min_c_q)) : '0;
		end
	end

endmodule
`default_nettype wire

// ----- dv/key_frequency_min_max_tracker_tb.sv -----
`default_nettype none
module key_frequency_min_max_tracker_tb;
	import kfmm_pkg::*;

	localparam int SLOTS = DEF_ENTRIES;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LATENCY = 2 * SLOTS + 5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t in_item = '0;
	logic done;
	out_item_t result;

	key_frequency_min_max_tracker uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_item(in_item), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	// Shadow of the frequency table.
	logic [31:0] tbl_key [SLOTS];
	logic [31:0] tbl_count [SLOTS];
	bit tbl_used [SLOTS];

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int send_idle_pct = 22;
	int errors = 0;
	int accepted = 0;
	int results_seen = 0;
	int watchdog = 0;
	int status_hits [4] = '{0, 0, 0, 0};

	function automatic out_item_t apply_transaction(in_item_t it);
		out_item_t r;
		int s, f, mx, mn;
		r = '0;
		s = -1;
		f = -1;
		mx = -1;
		mn = -1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (tbl_used[i] && tbl_key[i] == it.key) s = i;
			if (!tbl_used[i]) f = i;
		end
		if (it.action == ACT_INC) begin
			if (s >= 0) begin
				if (tbl_count[s] == 32'hFFFF_FFFF) r.status = ST_SATURATE;
				else tbl_count[s] = tbl_count[s] + 1;
				r.new_count = tbl_count[s];
			end else if (f < 0) begin
				r.status = ST_FULL;
			end else begin
				tbl_used[f] = 1'b1;
				tbl_key[f] = it.key;
				tbl_count[f] = 1;
				r.new_count = 1;
			end
		end else begin
			if (s < 0) begin
				r.status = ST_ABSENT;
			end else if (tbl_count[s] <= 1) begin
				tbl_used[s] = 1'b0;
				tbl_count[s] = 0;
			end else begin
				tbl_count[s] = tbl_count[s] - 1;
				r.new_count = tbl_count[s];
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (tbl_used[i]) begin
				if (mx < 0 || tbl_count[i] > tbl_count[mx]) mx = i;
				if (mn < 0 || tbl_count[i] < tbl_count[mn]) mn = i;
			end
		end
		if (mx < 0) begin
			r.table_empty = 1'b1;
		end else begin
			r.max_key = tbl_key[mx];
			r.max_count = tbl_count[mx];
			r.min_key = tbl_key[mn];
			r.min_count = tbl_count[mn];
		end
		return r;
	endfunction

	function automatic in_item_t mk(logic act, logic [31:0] k);
		in_item_t it;
		it.action = act;
		it.key = k;
		return it;
	endfunction

	// A small key pool keeps hits frequent; a few fully random keys exercise every bit.
	function automatic logic [31:0] pick_key(int pool);
		if ($urandom_range(0, 9) == 0) return $urandom;
		return 32'hA5A5_0000 ^ $urandom_range(0, pool - 1);
	endfunction

	// Driver: hold start until the transaction is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(apply_transaction(in_item));
				accepted <= accepted + 1;
			end
			if (!(start && busy)) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_item <= pending_items.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
					in_item <= {1'($urandom_range(0, 1)), 32'($urandom)};
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		out_item_t e;
		int miss;
		miss = 0;
		if (arst_n) begin
			if ((start && !busy) || done) watchdog <= 0;
			else watchdog <= watchdog + 1;
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
			if (done) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("Unexpected result, status %0d", result.status);
					miss++;
				end else begin
					e = expected_results.pop_front();
					status_hits[e.status] <= status_hits[e.status] + 1;
					if (result.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, result.status);
						miss++;
					end
					if (result.new_count !== e.new_count) begin
						$error("new_count: expected %0h, got %0h",
							e.new_count, result.new_count);
						miss++;
					end
					if (result.table_empty !== e.table_empty) begin
						$error("table_empty: expected %0d, got %0d",
							e.table_empty, result.table_empty);
						miss++;
					end
					if (result.max_key !== e.max_key) begin
						$error("max_key: expected %0h, got %0h", e.max_key, result.max_key);
						miss++;
					end
					if (result.max_count !== e.max_count) begin
						$error("max_count: expected %0h, got %0h",
							e.max_count, result.max_count);
						miss++;
					end
					if (result.min_key !== e.min_key) begin
						$error("min_key: expected %0h, got %0h", e.min_key, result.min_key);
						miss++;
					end
					if (result.min_count !== e.min_count) begin
						$error("min_count: expected %0h, got %0h",
							e.min_count, result.min_count);
						miss++;
					end
				end
				errors <= errors + miss;
			end
		end
	end

	task automatic drain();
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int n;
		int pool;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_key[i] = '0;
			tbl_count[i] = '0;
			tbl_used[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-table decrement, extreme keys, ties, removal, full table.
		pending_items.push_back(mk(ACT_DEC, 32'h0));
		pending_items.push_back(mk(ACT_INC, 32'h0));
		pending_items.push_back(mk(ACT_INC, 32'hFFFF_FFFF));
		pending_items.push_back(mk(ACT_INC, 32'hFFFF_FFFF));
		pending_items.push_back(mk(ACT_INC, 32'h8000_0001));
		pending_items.push_back(mk(ACT_DEC, 32'h1234_5678));
		pending_items.push_back(mk(ACT_DEC, 32'h0));
		pending_items.push_back(mk(ACT_DEC, 32'hFFFF_FFFF));
		pending_items.push_back(mk(ACT_INC, 32'h0));
		pending_items.push_back(mk(ACT_DEC, 32'h0));
		pending_items.push_back(mk(ACT_DEC, 32'hFFFF_FFFF));
		pending_items.push_back(mk(ACT_DEC, 32'h8000_0001));
		for (int i = 0; i < SLOTS; i++) pending_items.push_back(mk(ACT_INC, 32'h100 + i));
		pending_items.push_back(mk(ACT_INC, 32'h5555_AAAA));
		pending_items.push_back(mk(ACT_INC, 32'h100 + SLOTS - 1));
		pending_items.push_back(mk(ACT_DEC, 32'h100 + 7));
		pending_items.push_back(mk(ACT_INC, 32'hAAAA_5555));
		for (int i = 0; i < SLOTS; i++) pending_items.push_back(mk(ACT_DEC, 32'h100 + i));
		pending_items.push_back(mk(ACT_DEC, 32'hAAAA_5555));
		drain();

		// Random phases: sender idles 22%, then 47%, then never.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 47 : 0;
			n = 0;
			while (n < 250) begin
				// Bursts of mostly increments grow the table, sometimes to full, with some decrements.
				pool = ($urandom_range(0, 3) == 0) ? 80 : 24;
				repeat ($urandom_range(5, 40)) begin
					pending_items.push_back(mk($urandom_range(0, 99) < 65 ? ACT_INC : ACT_DEC,
						pick_key(pool)));
					n++;
				end
			end
			drain();
		end
		repeat (LATENCY + 10) @(posedge clk);
		$display("Checked %0d transactions, %0d results: %0d ok, %0d absent, %0d full,",
			accepted, results_seen, status_hits[0], status_hits[1], status_hits[2]);
		$display("%0d saturated. Count saturation is out of reach at 32-bit counts.",
			status_hits[3]);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
